// ===== hw/rtl/ppat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppat_pkg: shared types and codes of the peer pair allow table
// Operation and status codes, the normalized pair key and the token that
// walks along the row of table cells.
// ----------------------------------------------------------------------------
package ppat_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned USED_W = 7;

  // operation codes
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EQUAL   = 2'd3
  } status_t;

  // one input item as taken from the input channel
  typedef struct packed {
    logic              operation;
    logic [HALF_W-1:0] first_tag_high;
    logic [HALF_W-1:0] first_tag_low;
    logic [HALF_W-1:0] second_tag_high;
    logic [HALF_W-1:0] second_tag_low;
  } in_item_t;

  // normalized pair: smaller tag first
  typedef struct packed {
    logic [HALF_W-1:0] lo_hi;
    logic [HALF_W-1:0] lo_lo;
    logic [HALF_W-1:0] up_hi;
    logic [HALF_W-1:0] up_lo;
  } pair_key_t;

  // item in flight along the cell row
  typedef struct packed {
    logic      vld;
    logic      op;
    logic      equal;
    logic      hit;
    logic      stored;
    pair_key_t key;
  } token_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppat_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppat_in_if / ppat_out_if: valid/ready channels of the peer pair allow table
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ppat_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] first_tag_high;
  logic [63:0] first_tag_low;
  logic [63:0] second_tag_high;
  logic [63:0] second_tag_low;

  modport source (
    output valid, operation, first_tag_high, first_tag_low,
           second_tag_high, second_tag_low,
    input  ready
  );
  modport sink (
    input  valid, operation, first_tag_high, first_tag_low,
           second_tag_high, second_tag_low,
    output ready
  );
endinterface

interface ppat_out_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] status;
  logic [6:0] entries_used;

  modport source (output valid, allowed, status, entries_used, input ready);
  modport sink   (input valid, allowed, status, entries_used, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppat_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppat_norm: front stage
// Orders the two tags (unsigned, high half first) and launches a token
// into the cell row.
// ----------------------------------------------------------------------------
module ppat_norm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              item_vld,
  input  wire ppat_pkg::in_item_t item,
  output ppat_pkg::token_t       tok_o
);

  ppat_pkg::token_t tok_r, tok_nxt;
  logic [2*ppat_pkg::HALF_W-1:0] tag_a, tag_b;
  logic a_lt_b;

  assign tag_a  = {item.first_tag_high, item.first_tag_low};
  assign tag_b  = {item.second_tag_high, item.second_tag_low};
  assign a_lt_b = tag_a < tag_b;

  // normalize the pair
  always_comb begin
    tok_nxt        = '0;
    tok_nxt.vld    = item_vld;
    tok_nxt.op     = item.operation;
    tok_nxt.equal  = (tag_a == tag_b);
    tok_nxt.hit    = 1'b0;
    tok_nxt.stored = 1'b0;
    if (a_lt_b) begin
      tok_nxt.key = {tag_a, tag_b};
    end else begin
      tok_nxt.key = {tag_b, tag_a};
    end
  end

  // stage register; key needs no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r.op     <= tok_nxt.op;
      tok_r.equal  <= tok_nxt.equal;
      tok_r.hit    <= tok_nxt.hit;
      tok_r.stored <= tok_nxt.stored;
      tok_r.key    <= tok_nxt.key;
    end
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ppat_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppat_cell: one table entry
// Holds one normalized pair, compares it with the passing token, and takes
// the pair of an unmatched insert if this is the first free entry.
// ----------------------------------------------------------------------------
module ppat_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire ppat_pkg::token_t tok_i,
  output ppat_pkg::token_t      tok_o,
  output logic                  vld_o
);

  ppat_pkg::token_t  tok_r, tok_nxt;
  ppat_pkg::pair_key_t pair_r;
  logic valid_r;
  logic match, take;

  // entries fill in order, so the first free entry sees every stored pair
  assign match = tok_i.vld && valid_r && !tok_i.equal && (tok_i.key == pair_r);
  assign take  = tok_i.vld && !valid_r && (tok_i.op == ppat_pkg::OP_INSERT) &&
                 !tok_i.equal && !tok_i.hit && !tok_i.stored;

  always_comb begin
    tok_nxt        = tok_i;
    tok_nxt.hit    = tok_i.hit | match;
    tok_nxt.stored = tok_i.stored | take;
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (adv && take) begin
      pair_r <= tok_i.key;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv && take) begin
      valid_r <= 1'b1;
    end
  end

  // hand the token on
  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r.op     <= tok_nxt.op;
      tok_r.equal  <= tok_nxt.equal;
      tok_r.hit    <= tok_nxt.hit;
      tok_r.stored <= tok_nxt.stored;
      tok_r.key    <= tok_nxt.key;
    end
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  assign tok_o = tok_r;
  assign vld_o = valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/peer_pair_allow_table_core.sv =====
`default_nettype none
// Path from input transfer to result valid: the front stage register takes the
//   transfer, then one register per table cell, then the output register.
// Throughput: one item per cycle while the output is not stalled; items follow each other down the cell row.
// Back-pressure on the output stalls the whole row.
// Reset empties the table and the pair count at once; no clearing pass.
// ----------------------------------------------------------------------------
// peer_pair_allow_table_core: allowed peer pair table
// Normalized tag pairs walk a row of entry cells; each cell compares and the
// first free cell stores a new pair on insert.
// ----------------------------------------------------------------------------
module peer_pair_allow_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppat_in_if.sink    in_ch,
  ppat_out_if.source out_ch
);

  ppat_pkg::in_item_t item;
  ppat_pkg::token_t   tok_chain [ENTRIES+1];
  ppat_pkg::token_t   tail;
  logic [ENTRIES-1:0] cell_vld;
  logic               adv;

  logic                        out_valid_r, out_valid_nxt;
  logic                        allowed_r, allowed_nxt;
  ppat_pkg::status_t           status_r, status_nxt;
  logic [ppat_pkg::USED_W-1:0] count_r, count_nxt;

  // whole row moves unless a result waits
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign item.operation       = in_ch.operation;
  assign item.first_tag_high  = in_ch.first_tag_high;
  assign item.first_tag_low   = in_ch.first_tag_low;
  assign item.second_tag_high = in_ch.second_tag_high;
  assign item.second_tag_low  = in_ch.second_tag_low;

  ppat_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item_vld (in_ch.valid),
    .item     (item),
    .tok_o    (tok_chain[0])
  );

  // entry cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ppat_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_chain[i]),
      .tok_o (tok_chain[i+1]),
      .vld_o (cell_vld[i])
    );
  end

  assign tail = tok_chain[ENTRIES];

  // result decode at the end of the row
  always_comb begin
    out_valid_nxt = out_valid_r;
    allowed_nxt   = allowed_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    if (adv) begin
      out_valid_nxt = tail.vld;
      if (tail.vld) begin
        count_nxt = count_r + ppat_pkg::USED_W'(tail.stored);
        if (tail.equal) begin
          allowed_nxt = 1'b0;
          status_nxt  = ppat_pkg::STAT_EQUAL;
        end else if (tail.hit) begin
          allowed_nxt = 1'b1;
          status_nxt  = (tail.op == ppat_pkg::OP_INSERT) ? ppat_pkg::STAT_PRESENT
                                                         : ppat_pkg::STAT_OK;
        end else if (tail.op == ppat_pkg::OP_INSERT) begin
          allowed_nxt = tail.stored;
          status_nxt  = tail.stored ? ppat_pkg::STAT_OK : ppat_pkg::STAT_FULL;
        end else begin
          allowed_nxt = 1'b0;
          status_nxt  = ppat_pkg::STAT_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    allowed_r <= allowed_nxt;
    status_r  <= status_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.allowed      = allowed_r;
  assign out_ch.status       = status_r;
  assign out_ch.entries_used = count_r;

  // occupied entries always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld + ENTRIES'(1)) & cell_vld) == '0)
    else $error("table entries not filled in order");

  // equal tags are never allowed
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ppat_pkg::STAT_EQUAL) |-> !allowed_r)
    else $error("equal tags reported allowed");

  // a full report only when every entry is occupied
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ppat_pkg::STAT_FULL) |-> (&cell_vld))
    else $error("full status with a free entry");

  // a waiting result holds off new input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire
